[src/pid_with_twiddle_adaptive_tuning_core_assert.svh]
// Assertion helpers shared by the RTL of the PID core.
`ifndef PID_WITH_TWIDDLE_ADAPTIVE_TUNING_CORE_ASSERT_SVH
`define PID_WITH_TWIDDLE_ADAPTIVE_TUNING_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PWT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define PWT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/pwt_pkg.sv]
`timescale 1ns / 1ps
package pwt_pkg;

   localparam int ERR_W     = 24;
   localparam int ERR_FRAC  = 16;
   localparam int GAIN_W    = 48;
   localparam int GAIN_FRAC = 32;
   localparam int ESUM_W    = 40;
   localparam int WIN_W     = 64;
   localparam int LIMIT_W   = 39;
   localparam int MUL_A_W   = 72;
   localparam int MUL_B_W   = 64;
   localparam int MUL_P_W   = 136;
   localparam int DIGIT_W   = 8;
   localparam int DIGITS    = MUL_B_W / DIGIT_W;

   typedef logic signed [MUL_A_W-1:0] mul_a_type;
   typedef logic signed [MUL_B_W-1:0] mul_b_type;
   typedef logic signed [MUL_P_W-1:0] wide_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

   // register indexes of the csr port
   localparam logic [2:0] CSR_P_GAIN   = 3'd0;
   localparam logic [2:0] CSR_I_GAIN   = 3'd1;
   localparam logic [2:0] CSR_D_GAIN   = 3'd2;
   localparam logic [2:0] CSR_MAX_OUT  = 3'd3;
   localparam logic [2:0] CSR_MODE     = 3'd4;
   localparam logic [2:0] CSR_SETTLE   = 3'd5;
   localparam logic [2:0] CSR_EVAL     = 3'd6;

   localparam logic [1:0] MODE_FIXED   = 2'd0;
   localparam logic [1:0] MODE_TWIDDLE = 2'd1;
   localparam logic [1:0] MODE_ADAPT   = 2'd2;
   localparam logic [1:0] MODE_UNUSED  = 2'd3;

   // gain slots: P, D, I
   localparam logic [1:0] K_P = 2'd0;
   localparam logic [1:0] K_D = 2'd1;
   localparam logic [1:0] K_I = 2'd2;

   // floor(n/5) = (n * RECIP5) >> 34 for n below 2^32
   localparam mul_b_type RECIP5     = 64'sh0000_0000_CCCC_CCCD;
   localparam int        RECIP5_SH  = 34;
   localparam mul_b_type GROW_Q32   = 64'sd4509715661;
   localparam mul_b_type SHRINK_Q32 = 64'sd4080218931;
   localparam mul_b_type ADAPT_P    = 64'sd281474977;
   localparam mul_b_type ADAPT_I    = 64'sd2814750;
   localparam mul_b_type ADAPT_D    = 64'sd281474976711;
   localparam int        ADAPT_SH   = 2 * ERR_FRAC + 48 - GAIN_FRAC;
   localparam int        OUT_SH     = ERR_FRAC + GAIN_FRAC - 16;
   localparam int        SLIDE_GAIN = 30;

   // saturate a wide signed value to w bits (w up to 64)
   function automatic logic signed [63:0] sat_w(input wide_type x, input int w);
      wide_type hi;
      wide_type lo;
      hi = (wide_type'(1) <<< (w - 1)) - wide_type'(1);
      lo = -hi - wide_type'(1);
      if (x > hi) sat_w = hi[63:0];
      else if (x < lo) sat_w = lo[63:0];
      else sat_w = x[63:0];
   endfunction

   // floor(b * 2^18 / 5) for the remainder b of the drive limit / 5
   function automatic logic [17:0] fifth_frac(input logic [2:0] b);
      case (b)
         3'd0: fifth_frac = 18'd0;
         3'd1: fifth_frac = 18'd52428;
         3'd2: fifth_frac = 18'd104857;
         3'd3: fifth_frac = 18'd157286;
         3'd4: fifth_frac = 18'd209715;
         default: fifth_frac = 18'd0;
      endcase
   endfunction

   function automatic logic [1:0] next_k(input logic [1:0] k);
      next_k = (k == K_I) ? K_P : k + 2'd1;
   endfunction

endpackage

[src/pid_with_twiddle_adaptive_tuning_core.sv]
`timescale 1ns / 1ps
// PID steering core with twiddle / adaptive gain tuning. One error word in
// gives one result word out (drive, integral clamped after the first
// sample, live gains). All products run through a single digit-serial
// 72x9 multiplier, and the step-count modulo runs one bit a cycle.
// req_tready is high only while idle; a finished result may wait in the
// output register while the next word is taken in. csr_ready is always
// high.
module pid_with_twiddle_adaptive_tuning_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // error_in
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [207:0] rsp_tdata,   // control_out, integral_limited,
                                     // p_gain_now, i_gain_now, d_gain_now
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [47:0]  csr_data
);

`include "pid_with_twiddle_adaptive_tuning_core_assert.svh"

   typedef enum logic [4:0] {
      S_IDLE, S_MOD, S_LIM_GO, S_LIM_USE, S_INT_GO, S_INT_USE, S_SQ_GO, S_SQ_USE,
      S_TW0, S_TWG_GO, S_TWG_USE, S_TW_ACT, S_TWS_GO, S_TWS_USE,
      S_AD1_GO, S_AD1_USE, S_AD2_GO, S_AD2_USE, S_OUT_GO, S_OUT_USE,
      S_DONE, S_MWAIT
   } state_type;

   state_type state_ff, ret_ff;

   // configuration
   logic signed [47:0] cfg_gain_ff [3];
   logic [22:0]        max_out_ff;
   logic [1:0]         mode_ff;
   logic [15:0]        settle_ff, eval_ff;

   // controller state
   logic signed [23:0] e_ff, p_ff, last_ff;
   logic signed [24:0] delta_ff;
   logic signed [39:0] esum_ff;
   logic signed [47:0] integ_ff;
   logic signed [31:0] z_ff;
   logic               started_ff, first_ff, firstwin_ff;
   logic [31:0]        step_count_ff;
   logic [63:0]        win_ff, best_ff;
   logic signed [47:0] step_ff [3];
   logic signed [47:0] gain_ff [3];
   logic [1:0]         ti_ff, k_ff, j_ff;
   logic               tu_ff, td_ff;
   logic [38:0]        limit_ff;
   logic [16:0]        rem_ff;
   logic [31:0]        divq_ff;
   logic [4:0]         dcnt_ff;
   logic signed [71:0] prod1_ff;
   logic signed [95:0] sum_ff;

   logic               rsp_valid_ff;
   logic [207:0]       rsp_data_ff;

   // multiplier
   logic                  mul_start;
   pwt_pkg::mul_a_type    mul_a;
   pwt_pkg::mul_b_type    mul_b;
   pwt_pkg::mul_stat_type mul_stat;
   pwt_pkg::wide_type     prod;

   pwt_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .stat  (mul_stat),
      .prod  (prod)
   );

   // input-side values
   logic signed [23:0] e_req, p_req;
   logic signed [24:0] ne_req, ne_cur, delta_in;
   logic signed [39:0] esum_in;
   logic signed [31:0] z_in;
   logic [15:0]        s_eff, v_eff;
   logic [16:0]        period;
   logic [17:0]        div_t;
   logic [20:0]        lim_q;
   logic [2:0]         lim_b;
   logic [38:0]        limit_in;
   logic signed [48:0] inc49;
   logic signed [49:0] acc50, lim50;
   logic signed [47:0] integ_in;
   logic [64:0]        win_sum;
   logic [63:0]        win_in;
   logic signed [71:0] x_sel;
   logic signed [47:0] g_sel;
   logic [1:0]         gidx;
   pwt_pkg::mul_b_type c_sel;
   logic signed [48:0] adj49;
   logic signed [47:0] gain_adj;
   logic [1:0]         kk;
   logic signed [49:0] tw_sum;
   logic signed [49:0] tw_amt;
   logic signed [95:0] sum_in;
   logic signed [31:0] ctl_out;

   always_comb begin
      e_req  = $signed(req_tdata);
      ne_req = -{e_req[23], e_req};
      p_req  = (ne_req == 25'sh0800000) ? 24'sh7FFFFF : ne_req[23:0];
      delta_in = {p_req[23], p_req} - {last_ff[23], last_ff};
      esum_in  = 40'(pwt_pkg::sat_w(pwt_pkg::wide_type'(esum_ff) +
                                    pwt_pkg::wide_type'(p_req), pwt_pkg::ESUM_W));
      z_in = -(32'(p_req) * 32'(pwt_pkg::SLIDE_GAIN) + 32'(delta_in));
      ne_cur = -{e_ff[23], e_ff};

      s_eff  = (settle_ff == 16'd0) ? 16'd1 : settle_ff;
      v_eff  = (eval_ff == 16'd0) ? 16'd1 : eval_ff;
      period = {1'b0, s_eff} + {1'b0, v_eff};
      div_t  = {rem_ff, divq_ff[31]};
      if (div_t >= {1'b0, period}) div_t = div_t - {1'b0, period};

      lim_q    = prod[pwt_pkg::RECIP5_SH +: 21];
      lim_b    = 3'(max_out_ff - 23'(lim_q) * 23'd5);
      limit_in = {lim_q, 18'd0} + 39'(pwt_pkg::fifth_frac(lim_b));

      inc49 = 49'(pwt_pkg::sat_w(prod >>> pwt_pkg::ERR_FRAC, 49));
      acc50 = 50'(integ_ff) + 50'(inc49);
      lim50 = $signed({11'd0, limit_ff});
      if (acc50 > lim50) acc50 = lim50;
      else if (acc50 < -lim50) acc50 = -lim50;
      if (first_ff) begin
         integ_in = 48'(pwt_pkg::sat_w(prod >>> pwt_pkg::ERR_FRAC, pwt_pkg::GAIN_W));
      end else begin
         integ_in = acc50[47:0];
      end

      win_sum = {1'b0, win_ff} + {1'b0, prod[63:0]};
      win_in  = win_sum[64] ? '1 : win_sum[63:0];

      case (j_ff)
         2'd0: begin
            x_sel = 72'(p_ff);
            gidx  = pwt_pkg::K_P;
            c_sel = pwt_pkg::ADAPT_P;
         end
         2'd1: begin
            x_sel = 72'(esum_ff);
            gidx  = pwt_pkg::K_I;
            c_sel = pwt_pkg::ADAPT_I;
         end
         default: begin
            x_sel = 72'(delta_ff);
            gidx  = pwt_pkg::K_D;
            c_sel = pwt_pkg::ADAPT_D;
         end
      endcase
      g_sel    = gain_ff[gidx];
      adj49    = 49'(pwt_pkg::sat_w(prod >>> pwt_pkg::ADAPT_SH, 49));
      gain_adj = 48'(pwt_pkg::sat_w(pwt_pkg::wide_type'(g_sel) -
                                    pwt_pkg::wide_type'(adj49), pwt_pkg::GAIN_W));

      kk = (ti_ff > pwt_pkg::K_I) ? pwt_pkg::K_I : ti_ff;
      // -2*step needs 50 bits when the step sits at its negative limit
      if (tu_ff && !td_ff) tw_amt = -(50'(step_ff[k_ff]) <<< 1);
      else tw_amt = 50'(step_ff[k_ff]);
      tw_sum = 50'(gain_ff[k_ff]) + tw_amt;

      sum_in  = ((j_ff == 2'd0) ? 96'sd0 : sum_ff) + prod[95:0];
      ctl_out = 32'(pwt_pkg::sat_w(pwt_pkg::wide_type'(sum_ff) >>> pwt_pkg::OUT_SH, 32));

      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         S_LIM_GO: begin
            mul_start = 1'b1;
            mul_a     = $signed({49'd0, max_out_ff});
            mul_b     = pwt_pkg::RECIP5;
         end
         S_INT_GO: begin
            mul_start = 1'b1;
            mul_a     = 72'(ne_cur);
            mul_b     = 64'(gain_ff[pwt_pkg::K_I]);
         end
         S_SQ_GO: begin
            mul_start = 1'b1;
            mul_a     = 72'(e_ff);
            mul_b     = 64'(e_ff);
         end
         S_TWG_GO, S_TWS_GO: begin
            mul_start = 1'b1;
            mul_a     = 72'(step_ff[k_ff]);
            mul_b     = (state_ff == S_TWG_GO) ? pwt_pkg::GROW_Q32 : pwt_pkg::SHRINK_Q32;
         end
         S_AD1_GO: begin
            mul_start = 1'b1;
            mul_a     = x_sel;
            mul_b     = 64'(z_ff);
         end
         S_AD2_GO: begin
            mul_start = 1'b1;
            mul_a     = prod1_ff;
            mul_b     = c_sel;
         end
         S_OUT_GO: begin
            mul_start = 1'b1;
            mul_a     = x_sel;
            mul_b     = 64'(g_sel);
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ret_ff        <= S_IDLE;
         cfg_gain_ff   <= '{default: '0};
         max_out_ff    <= 23'd65536;
         mode_ff       <= pwt_pkg::MODE_FIXED;
         settle_ff     <= 16'd100;
         eval_ff       <= 16'd200;
         last_ff       <= '0;
         esum_ff       <= '0;
         delta_ff      <= '0;
         integ_ff      <= '0;
         started_ff    <= 1'b0;
         first_ff      <= 1'b0;
         step_count_ff <= 32'd1;
         win_ff        <= '0;
         best_ff       <= '1;
         step_ff       <= '{default: '0};
         gain_ff       <= '{default: '0};
         ti_ff         <= pwt_pkg::K_I;
         tu_ff         <= 1'b0;
         td_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               pwt_pkg::CSR_P_GAIN:  cfg_gain_ff[pwt_pkg::K_P] <= $signed(csr_data);
               pwt_pkg::CSR_I_GAIN:  cfg_gain_ff[pwt_pkg::K_I] <= $signed(csr_data);
               pwt_pkg::CSR_D_GAIN:  cfg_gain_ff[pwt_pkg::K_D] <= $signed(csr_data);
               pwt_pkg::CSR_MAX_OUT: max_out_ff <= csr_data[22:0];
               pwt_pkg::CSR_MODE:    mode_ff    <= csr_data[1:0];
               pwt_pkg::CSR_SETTLE:  settle_ff  <= csr_data[15:0];
               pwt_pkg::CSR_EVAL:    eval_ff    <= csr_data[15:0];
               default: ;
            endcase
         end
         // S_DONE drives the valid itself
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  e_ff    <= e_req;
                  p_ff    <= p_req;
                  last_ff <= p_req;
                  j_ff    <= 2'd0;
                  if (!started_ff) begin
                     started_ff <= 1'b1;
                     first_ff   <= 1'b1;
                     delta_ff   <= '0;
                     esum_ff    <= 40'(p_req);
                     for (int k = 0; k < 3; k++) begin
                        gain_ff[k] <= cfg_gain_ff[k];
                        step_ff[k] <= cfg_gain_ff[k] >>> 1;
                     end
                     state_ff <= S_INT_GO;
                  end else begin
                     first_ff <= 1'b0;
                     delta_ff <= delta_in;
                     esum_ff  <= esum_in;
                     z_ff     <= z_in;
                     rem_ff   <= '0;
                     divq_ff  <= step_count_ff;
                     dcnt_ff  <= 5'd31;
                     state_ff <= S_MOD;
                  end
               end
            end
            S_MOD: begin
               rem_ff  <= div_t[16:0];
               divq_ff <= divq_ff << 1;
               dcnt_ff <= dcnt_ff - 5'd1;
               if (dcnt_ff == 5'd0) state_ff <= S_LIM_GO;
            end
            S_MWAIT: begin
               if (mul_stat.done) state_ff <= ret_ff;
            end
            S_LIM_GO: begin
               ret_ff   <= S_LIM_USE;
               state_ff <= S_MWAIT;
            end
            S_LIM_USE: begin
               limit_ff <= limit_in;
               state_ff <= S_INT_GO;
            end
            S_INT_GO: begin
               ret_ff   <= S_INT_USE;
               state_ff <= S_MWAIT;
            end
            S_INT_USE: begin
               integ_ff <= integ_in;
               state_ff <= first_ff ? S_OUT_GO : S_SQ_GO;
            end
            S_SQ_GO: begin
               ret_ff   <= S_SQ_USE;
               state_ff <= S_MWAIT;
            end
            S_SQ_USE: begin
               if (rem_ff > {1'b0, s_eff}) win_ff <= win_in;
               firstwin_ff   <= (step_count_ff == {15'd0, period});
               step_count_ff <= step_count_ff + 32'd1;
               if (mode_ff == pwt_pkg::MODE_TWIDDLE && rem_ff == '0) begin
                  state_ff <= S_TW0;
               end else if (mode_ff == pwt_pkg::MODE_ADAPT) begin
                  state_ff <= S_AD1_GO;
               end else begin
                  state_ff <= S_OUT_GO;
               end
            end
            S_TW0: begin
               if (win_ff < best_ff) begin
                  best_ff <= win_ff;
                  tu_ff   <= 1'b0;
                  td_ff   <= 1'b0;
                  if (!firstwin_ff) begin
                     k_ff     <= kk;
                     state_ff <= S_TWG_GO;
                  end else begin
                     k_ff     <= pwt_pkg::next_k(kk);
                     state_ff <= S_TW_ACT;
                  end
               end else begin
                  k_ff     <= kk;
                  state_ff <= S_TW_ACT;
               end
            end
            S_TWG_GO: begin
               ret_ff   <= S_TWG_USE;
               state_ff <= S_MWAIT;
            end
            S_TWG_USE: begin
               step_ff[k_ff] <= 48'(pwt_pkg::sat_w(prod >>> 32, pwt_pkg::GAIN_W));
               k_ff          <= pwt_pkg::next_k(k_ff);
               state_ff      <= S_TW_ACT;
            end
            S_TW_ACT: begin
               gain_ff[k_ff] <= 48'(pwt_pkg::sat_w(pwt_pkg::wide_type'(tw_sum),
                                                   pwt_pkg::GAIN_W));
               if (!tu_ff && !td_ff) begin
                  tu_ff    <= 1'b1;
                  ti_ff    <= k_ff;
                  win_ff   <= '0;
                  state_ff <= S_OUT_GO;
               end else if (tu_ff && !td_ff) begin
                  td_ff    <= 1'b1;
                  ti_ff    <= k_ff;
                  win_ff   <= '0;
                  state_ff <= S_OUT_GO;
               end else begin
                  state_ff <= S_TWS_GO;
               end
            end
            S_TWS_GO: begin
               ret_ff   <= S_TWS_USE;
               state_ff <= S_MWAIT;
            end
            S_TWS_USE: begin
               step_ff[k_ff] <= 48'(pwt_pkg::sat_w(prod >>> 32, pwt_pkg::GAIN_W));
               ti_ff         <= pwt_pkg::next_k(k_ff);
               tu_ff         <= 1'b0;
               td_ff         <= 1'b0;
               win_ff        <= '0;
               state_ff      <= S_OUT_GO;
            end
            S_AD1_GO: begin
               ret_ff   <= S_AD1_USE;
               state_ff <= S_MWAIT;
            end
            S_AD1_USE: begin
               prod1_ff <= prod[71:0];
               state_ff <= S_AD2_GO;
            end
            S_AD2_GO: begin
               ret_ff   <= S_AD2_USE;
               state_ff <= S_MWAIT;
            end
            S_AD2_USE: begin
               gain_ff[gidx] <= gain_adj;
               if (j_ff == 2'd2) begin
                  j_ff     <= 2'd0;
                  state_ff <= S_OUT_GO;
               end else begin
                  j_ff     <= j_ff + 2'd1;
                  state_ff <= S_AD1_GO;
               end
            end
            S_OUT_GO: begin
               ret_ff   <= S_OUT_USE;
               state_ff <= S_MWAIT;
            end
            S_OUT_USE: begin
               sum_ff <= sum_in;
               if (j_ff == 2'd2) begin
                  j_ff     <= 2'd0;
                  state_ff <= S_DONE;
               end else begin
                  j_ff     <= j_ff + 2'd1;
                  state_ff <= S_OUT_GO;
               end
            end
            S_DONE: begin
               // hold here while the previous word still sits unread
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= {gain_ff[pwt_pkg::K_D], gain_ff[pwt_pkg::K_I],
                                   gain_ff[pwt_pkg::K_P], integ_ff[47:16], ctl_out};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   `PWT_ASSERT_IMP(a_mul_only_in_wait, mul_stat.busy, state_ff == S_MWAIT, "multiplier busy outside wait")
   `PWT_ASSERT_IMP(a_down_after_up, td_ff, tu_ff, "twiddle tried down before up")
   `PWT_ASSERT_NXT(a_accept_leaves_idle, req_tvalid && req_tready, state_ff != S_IDLE, "accepted word dropped")
   `PWT_ASSERT_IMP(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff) == S_DONE, "result raised outside done")

endmodule

[src/pwt_mul.sv]
`timescale 1ns / 1ps
// Digit-serial signed multiplier: one 72x9 partial product per cycle,
// most significant digit of b first (that digit is signed).
module pwt_mul (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  pwt_pkg::mul_a_type  a,
   input  pwt_pkg::mul_b_type  b,
   output pwt_pkg::mul_stat_type stat,
   output pwt_pkg::wide_type   prod
);

   pwt_pkg::mul_a_type a_ff;
   pwt_pkg::mul_b_type b_ff;
   pwt_pkg::wide_type  acc_ff;
   pwt_pkg::wide_type  acc_in;
   logic [2:0]         cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic signed [8:0]  digit;
   logic signed [80:0] part;

   always_comb begin
      if (cnt_ff == 3'(pwt_pkg::DIGITS - 1)) begin
         digit = {b_ff[63], b_ff[63:56]};
      end else begin
         digit = {1'b0, b_ff[63:56]};
      end
      part   = a_ff * digit;
      acc_in = (acc_ff <<< pwt_pkg::DIGIT_W) + pwt_pkg::wide_type'(part);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            a_ff    <= a;
            b_ff    <= b;
            acc_ff  <= '0;
            cnt_ff  <= 3'(pwt_pkg::DIGITS - 1);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            acc_ff <= acc_in;
            b_ff   <= b_ff <<< pwt_pkg::DIGIT_W;
            cnt_ff <= cnt_ff - 3'd1;
            if (cnt_ff == 3'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign prod      = acc_ff;

endmodule
